/* design/rv32i_instruction_step_core_defines.svh */
// assertion macros shared by the rv32i step core
// no dependencies
`ifndef RV32I_INSTRUCTION_STEP_CORE_DEFINES_SVH
`define RV32I_INSTRUCTION_STEP_CORE_DEFINES_SVH
// assert that a implies b on the next clock
`define RVC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lbl failed");
// assert that a implies b in the same clock
`define RVC_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("lbl failed");
`endif

/* design/rvc_pkg.sv */
// types and constants for the rv32i step core
// no dependencies
`default_nettype none
package rvc_pkg;
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_OPIMM  = 7'd19;
  localparam logic [6:0] OPC_AUIPC  = 7'd23;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_OP     = 7'd51;
  localparam logic [6:0] OPC_LUI    = 7'd55;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [31:0] SP_RESET  = 32'h007F_FFFC;
  localparam logic [31:0] GP_RESET  = 32'h0010_0000;
  localparam logic [0:0] CFG_SP = 1'b0;
  localparam logic [0:0] CFG_GP = 1'b1;
  localparam logic [6:0] F7_ALT = 7'h20;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        illegal;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_done;
    logic        branch_taken;
  } result_t;
endpackage
`default_nettype wire

/* design/rvc_ram.sv */
// generic single-port-write ram with registered read port
// no dependencies
`default_nettype none
module rvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/rv32i_instruction_step_core.sv */
// rv32i step core: one byte load or one executed instruction per input word
// in/out words move on valid/stall; a small sequencer walks four byte-lane
// rams, two register-file rams and a result register. uses rvc_pkg, rvc_ram.
//
// usage: op 0 words write one memory byte, op 1 words execute the instruction
// at pc. every input word gives exactly one result word.
// timing: a byte load shows its result in the cycle after it is taken and the
// next word can follow at once. an instruction walks four states: idle (fetch
// read), register read, operand latch with data address read, finish (register
// or memory write); its result is registered at finish. loads and stores walk
// the same states. fetch and data access share the byte lane rams, one access
// per cycle, so the next word is taken only once the core is back in idle.
// in_stall is high outside idle and while a finished result waits under
// out_stall; the result register frees when out_stall drops.
// reset: pc 0, x2/x3 from the init registers; a clearing pass over all
// 2^(MEM_ADDR_BITS-2) lane rows then zeroes memory and the register file, with
// in_stall high. config writes belong between items and are also taken
// during the clearing pass.
`default_nettype none
`include "rv32i_instruction_step_core_defines.svh"
module rv32i_instruction_step_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [15:0] load_address,
  input  wire logic [7:0]  load_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      next_pc,
  output logic             halted,
  output logic             illegal,
  output logic             reg_write,
  output logic [4:0]       reg_index,
  output logic [31:0]      reg_value,
  output logic             store_done,
  output logic             branch_taken
);
  import rvc_pkg::*;

  localparam int WA = MEM_ADDR_BITS - 2;
  localparam int WDEPTH = 1 << WA;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_REG   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [WA:0] clr_cnt;
  logic [31:0] pc, sp_init, gp_init, insn, a_val, b_val, ls_addr, st_data;
  logic [1:0] ls_size;
  result_t res, res_next;
  logic out_full;

  // byte lane rams: lane k holds bytes with address[1:0] == k
  logic [3:0]       m_we;
  logic [WA-1:0]    m_waddr [4];
  logic [7:0]       m_wdata [4];
  logic [WA-1:0]    m_raddr [4];
  logic [7:0]       m_rdata [4];
  // two register file copies for two read ports
  logic             r_we;
  logic [4:0]       r_waddr, r_raddr_a, r_raddr_b;
  logic [31:0]      r_wdata, r_rdata_a, r_rdata_b;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    rvc_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_lane (
      .clk(clk), .we(m_we[k]), .waddr(m_waddr[k]), .wdata(m_wdata[k]),
      .raddr(m_raddr[k]), .rdata(m_rdata[k]));
  end
  rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr_a), .rdata(r_rdata_a));
  rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr_b), .rdata(r_rdata_b));

  wire idle_ok = (state == S_IDLE) && (!out_full || !out_stall);
  assign in_stall = !idle_ok;
  wire in_acc = in_valid && idle_ok;
  assign out_valid = out_full;
  wire out_set = (state == S_IDLE && in_acc && !op) || (state == S_DONE);
  wire [MEM_ADDR_BITS-1:0] la_ext = MEM_ADDR_BITS'(load_address);

  // lane row of the byte base+j that falls in lane k
  function automatic logic [WA-1:0] lane_addr(input logic [31:0] base,
                                              input int k);
    logic [MEM_ADDR_BITS-1:0] b, t;
    logic [1:0] off;
    b = base[MEM_ADDR_BITS-1:0];
    off = 2'(k) - b[1:0];
    t = b + MEM_ADDR_BITS'(off);
    return t[MEM_ADDR_BITS-1:2];
  endfunction

  // assembled memory word starting at base
  logic [31:0] rd_word;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_word[8*i +: 8] = m_rdata[2'(i) + ls_addr[1:0]];
    end
  end

  // word at pc from the lane rams (read issued in idle)
  logic [31:0] fetch_word;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fetch_word[8*i +: 8] = m_rdata[2'(i) + pc[1:0]];
    end
  end

  // decode
  wire [6:0] opc = insn[6:0];
  wire [4:0] rd  = insn[11:7];
  wire [2:0] f3  = insn[14:12];
  wire [6:0] f7  = insn[31:25];
  wire [31:0] imm_i = {{20{insn[31]}}, insn[31:20]};
  wire [31:0] imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
  wire [31:0] imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  wire [31:0] imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
  wire [31:0] imm_u = {insn[31:12], 12'd0};
  // data address from the freshly read base register
  wire [31:0] ea = r_rdata_a + (insn[5] ? imm_s : imm_i);
  wire [31:0] alu_b = (opc == OPC_OP) ? b_val : imm_i;
  wire alt = (opc == OPC_OP) ? (f7 == F7_ALT) : (f3 == 3'd5 && f7 == F7_ALT);
  wire slt  = $signed(a_val) < $signed(alu_b);
  wire sltu = a_val < alu_b;
  logic [31:0] alu_y;
  always_comb begin
    case (f3)
      3'd0: alu_y = alt ? a_val - alu_b : a_val + alu_b;
      3'd1: alu_y = a_val << alu_b[4:0];
      3'd2: alu_y = {31'd0, slt};
      3'd3: alu_y = {31'd0, sltu};
      3'd4: alu_y = a_val ^ alu_b;
      3'd5: alu_y = alt ? 32'($signed(a_val) >>> alu_b[4:0]) : a_val >> alu_b[4:0];
      3'd6: alu_y = a_val | alu_b;
      default: alu_y = a_val & alu_b;
    endcase
  end
  wire bslt  = $signed(a_val) < $signed(b_val);
  wire bsltu = a_val < b_val;
  logic bcond, bill;
  always_comb begin
    bill = 1'b0;
    case (f3)
      3'd0: bcond = a_val == b_val;
      3'd1: bcond = a_val != b_val;
      3'd4: bcond = bslt;
      3'd5: bcond = !bslt;
      3'd6: bcond = bsltu;
      3'd7: bcond = !bsltu;
      default: begin bcond = 1'b0; bill = 1'b1; end
    endcase
  end

  // execute-stage outcome
  logic [31:0] x_npc, x_val;
  logic x_ill, x_wr, x_tk, x_ld, x_st;
  always_comb begin
    x_npc = pc + 32'd4; x_val = '0; x_ill = 1'b0; x_wr = 1'b0; x_tk = 1'b0;
    x_ld = 1'b0; x_st = 1'b0;
    unique case (opc)
      OPC_LOAD: if (f3 > 3'd2) x_ill = 1'b1; else x_ld = 1'b1;
      OPC_STORE: if (f3 > 3'd2) x_ill = 1'b1; else x_st = 1'b1;
      OPC_OPIMM: begin
        if ((f3 == 3'd1 && f7 != 7'd0) ||
            (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT)) x_ill = 1'b1;
        else begin x_val = alu_y; x_wr = 1'b1; end
      end
      OPC_OP: begin
        if (f7 != 7'd0 && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) x_ill = 1'b1;
        else begin x_val = alu_y; x_wr = 1'b1; end
      end
      OPC_LUI: begin x_val = imm_u; x_wr = 1'b1; end
      OPC_AUIPC: begin x_val = pc + imm_u; x_wr = 1'b1; end
      OPC_JAL: begin
        x_val = pc + 32'd4; x_wr = 1'b1; x_npc = pc + imm_j; x_tk = 1'b1;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) x_ill = 1'b1;
        else begin
          x_val = pc + 32'd4; x_wr = 1'b1; x_tk = 1'b1;
          x_npc = (a_val + imm_i) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        x_ill = bill;
        if (bcond) begin x_npc = pc + imm_b; x_tk = 1'b1; end
      end
      default: x_ill = 1'b1;
    endcase
  end

  wire [31:0] ld_val = (ls_size == 2'd0) ? {{24{rd_word[7]}}, rd_word[7:0]} :
                       (ls_size == 2'd1) ? {{16{rd_word[15]}}, rd_word[15:0]} : rd_word;
  wire [2:0] st_mask = (ls_size == 2'd0) ? 3'd1 : (ls_size == 2'd1) ? 3'd2 : 3'd4;

  always_comb begin
    res_next = '0;
    if (insn == 32'd0) begin
      res_next.next_pc = pc; res_next.halted = 1'b1;
    end else begin
      res_next.next_pc = x_npc;
      res_next.illegal = x_ill;
      res_next.reg_write = (x_wr || x_ld) && rd != 5'd0;
      res_next.reg_index = res_next.reg_write ? rd : 5'd0;
      res_next.reg_value = !res_next.reg_write ? '0 : x_ld ? ld_val : x_val;
      res_next.store_done = x_st;
      res_next.branch_taken = x_tk;
    end
  end

  // memory and register file ports
  always_comb begin
    logic [1:0] rel;
    m_we = '0; r_we = 1'b0; r_waddr = rd; r_wdata = res_next.reg_value;
    r_raddr_a = fetch_word[19:15]; r_raddr_b = fetch_word[24:20];
    for (int k = 0; k < 4; k++) begin
      rel = 2'(k) - ls_addr[1:0];
      m_waddr[k] = lane_addr(ls_addr, k);
      m_raddr[k] = lane_addr(pc, k);
      m_wdata[k] = st_data[8*rel +: 8];
    end
    if (state == S_CLEAR) begin
      m_we = 4'hF;
      for (int k = 0; k < 4; k++) begin
        m_waddr[k] = clr_cnt[WA-1:0];
        m_wdata[k] = '0;
      end
      r_we = 1'b1; r_waddr = clr_cnt[4:0];
      r_wdata = (clr_cnt[4:0] == 5'd2) ? sp_init :
                (clr_cnt[4:0] == 5'd3) ? gp_init : '0;
    end else if (state == S_IDLE && in_acc && !op) begin
      m_we[la_ext[1:0]] = 1'b1;
      for (int k = 0; k < 4; k++) begin
        m_waddr[k] = la_ext[MEM_ADDR_BITS-1:2];
        m_wdata[k] = load_byte;
      end
    end else if (state == S_EXEC) begin
      for (int k = 0; k < 4; k++) m_raddr[k] = lane_addr(ea, k);
    end else if (state == S_DONE) begin
      r_we = res_next.reg_write;
      if (x_st) begin
        for (int k = 0; k < 4; k++) begin
          rel = 2'(k) - ls_addr[1:0];
          m_we[k] = ({1'b0, rel} < st_mask);
        end
      end
    end
    if (cfg_we) begin
      r_we = 1'b1; r_waddr = (cfg_index == CFG_SP) ? 5'd2 : 5'd3; r_wdata = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; pc <= '0; out_full <= 1'b0;
      sp_init <= SP_RESET; gp_init <= GP_RESET;
    end else begin
      if (cfg_we && cfg_index == CFG_SP) sp_init <= cfg_data;
      if (cfg_we && cfg_index == CFG_GP) gp_init <= cfg_data;
      if (out_set) out_full <= 1'b1;
      else if (out_full && !out_stall) out_full <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (WA+1)'(WDEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_acc) begin
          if (!op) res <= '{next_pc: pc, default: '0};
          else state <= S_REG;
        end
        S_REG: begin
          insn <= fetch_word;
          state <= S_EXEC;
        end
        S_EXEC: begin
          a_val <= r_rdata_a; b_val <= r_rdata_b;
          ls_addr <= ea;
          st_data <= r_rdata_b; ls_size <= f3[1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          // operands and load data valid, finish
          res <= res_next;
          pc <= res_next.next_pc;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign next_pc = res.next_pc;
  assign halted = res.halted;
  assign illegal = res.illegal;
  assign reg_write = res.reg_write;
  assign reg_index = res.reg_index;
  assign reg_value = res.reg_value;
  assign store_done = res.store_done;
  assign branch_taken = res.branch_taken;

  `RVC_ASSERT_NEXT(a_busy_stall, state == S_REG, in_stall)
  `RVC_ASSERT_NOW(a_halt_no_wr, out_valid && halted, !reg_write && !store_done)
  `RVC_ASSERT_NOW(a_x0_quiet, out_valid && !reg_write, reg_index == 5'd0)
  `RVC_ASSERT_NOW(a_ill_no_wr, out_valid && illegal, !reg_write && !store_done)
endmodule
`default_nettype wire
